FILE: hdl/ffha_pkg.sv
// Package for the first-fit hole allocator: sizes, op and error codes, state type.
// No dependencies.
package ffha_pkg;
    localparam int MaxHoles = 64;
    localparam int IdxW = $clog2(MaxHoles);
    localparam int CntW = IdxW + 1;
    localparam logic [32:0] PageBytes = 33'd1024;
    localparam logic [32:0] AlignBytes = 33'd8;
    localparam logic [31:0] HeaderBytes = 32'd4;
    localparam logic [32:0] PtrBytes = 33'd4;

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE = 2'd1,
        OP_RESIZE = 2'd2,
        OP_NONE = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ERR_NONE = 2'd0,
        ERR_OOM = 2'd1,
        ERR_FULL = 2'd2
    } t_err;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISPATCH,
        S_G_SCAN,
        S_G_SCAN_W,
        S_G_GROW,
        S_G_TAKE_RD,
        S_G_TAKE_W,
        S_G_TAKE,
        S_G_DROP_RD,
        S_G_DROP_W,
        S_G_DROP_WR,
        S_A_SCAN,
        S_A_SCAN_W,
        S_A_PREV_RD,
        S_A_PREV_W,
        S_A_NEXT_W,
        S_A_DECIDE,
        S_A_MDROP_RD,
        S_A_MDROP_W,
        S_A_MDROP_WR,
        S_A_INS_RD,
        S_A_INS_W,
        S_A_INS_WR,
        S_A_DONE,
        S_OUT
    } t_state;
endpackage

FILE: hdl/first_fit_hole_allocator.sv
// First-fit hole allocator top level: sequencer, hole table memory, APB registers.
// Depends on ffha_pkg.
// Each request scans the hole table in order and may shift entries on insert or remove.
// Throughput: one request at a time; stall stays high until the result transfers.
// One hole-table read port with registered data sets the scan pace.
// Reset (synchronous, active low): empty table, break at heap base, free total zero.
module first_fit_hole_allocator
    import ffha_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_op,
    input  logic [31:0] i_user_address,
    input  logic [31:0] i_block_header_size,
    input  logic [31:0] i_request_bytes,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_result_address,
    output logic [31:0] o_granted_size,
    output logic        o_success,
    output logic [1:0]  o_error_code,
    output logic        o_moved,
    output logic [31:0] o_free_total
);
    logic [63:0] r_mem [MaxHoles];
    logic [63:0] r_rd;
    logic        mem_we;
    logic [IdxW-1:0] mem_wa, mem_ra;
    logic [63:0] mem_wd;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rd <= r_mem[mem_ra];
    end

    t_state r_state, n_state;
    logic [31:0] r_hbase, r_hlim, r_brk, r_free, n_brk, n_free;
    logic [CntW-1:0] r_cnt, n_cnt, r_i, n_i, r_j, n_j;
    logic [1:0]  r_op;
    logic [31:0] r_ua, r_hdr, r_req;
    logic [32:0] r_need, n_need;
    // add-hole operands, and the caller (alloc grow / free / resize old)
    logic [31:0] r_ab, r_al, n_ab, n_al;
    logic [1:0]  r_ctx, n_ctx;
    logic [63:0] r_prev, n_prev;
    logic        r_hasprev, n_hasprev;
    logic [31:0] r_oaddr, r_ogr, r_ofree, n_oaddr, n_ogr, n_ofree;
    logic        r_ook, r_omv, r_ovalid, n_ook, n_omv, n_ovalid;
    logic [1:0]  r_oerr, n_oerr;

    localparam logic [1:0] C_GROW = 2'd0, C_FREE = 2'd1, C_OLD = 2'd2, C_MOVE = 2'd3;

    logic wr_cfg;
    assign pready = 1'b1;
    assign wr_cfg = psel & penable & pwrite;
    assign prdata = paddr[2] ? r_hlim : r_hbase;

    logic [31:0] e_base, e_len, p_end, old_pay;
    logic [32:0] chunk, nbrk, lim, need_c;
    assign e_base = r_rd[63:32];
    assign e_len = r_rd[31:0];
    assign p_end = r_prev[63:32] + r_prev[31:0];
    assign chunk = (r_need + PageBytes - 33'd1) & ~(PageBytes - 33'd1);
    assign nbrk = {1'b0, r_brk} + chunk;
    assign lim = {1'b0, r_hbase} + {1'b0, r_hlim};
    assign old_pay = (r_hdr >= HeaderBytes) ? r_hdr - HeaderBytes : 32'd0;
    always_comb begin
        need_c = (r_req < PtrBytes[31:0]) ? PtrBytes : {1'b0, r_req};
        need_c = (need_c + {1'b0, HeaderBytes} + AlignBytes - 33'd1) & ~(AlignBytes - 33'd1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_hbase <= 32'd65536;
            r_hlim <= 32'd1048576;
            r_brk <= 32'd65536;
            r_free <= '0;
            r_cnt <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_free <= n_free;
            r_cnt <= n_cnt;
            r_ovalid <= n_ovalid;
            if (wr_cfg && !paddr[2]) begin
                r_hbase <= pwdata;
                r_brk <= pwdata;
            end else begin
                r_brk <= n_brk;
            end
            if (wr_cfg && paddr[2]) begin
                r_hlim <= pwdata;
            end
        end
        if (i_valid && !o_stall) begin
            r_op <= i_op;
            r_ua <= i_user_address;
            r_hdr <= i_block_header_size;
            r_req <= i_request_bytes;
        end
        r_i <= n_i; r_j <= n_j; r_need <= n_need;
        r_ab <= n_ab; r_al <= n_al; r_ctx <= n_ctx;
        r_prev <= n_prev; r_hasprev <= n_hasprev;
        r_oaddr <= n_oaddr; r_ogr <= n_ogr; r_ofree <= n_ofree;
        r_ook <= n_ook; r_omv <= n_omv; r_oerr <= n_oerr;
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_ovalid;
    assign o_result_address = r_oaddr;
    assign o_granted_size = r_ogr;
    assign o_success = r_ook;
    assign o_error_code = r_oerr;
    assign o_moved = r_omv;
    assign o_free_total = r_ofree;

    always_comb begin
        n_state = r_state; n_brk = r_brk; n_free = r_free; n_cnt = r_cnt;
        n_i = r_i; n_j = r_j; n_need = r_need; n_ab = r_ab; n_al = r_al;
        n_ctx = r_ctx; n_prev = r_prev; n_hasprev = r_hasprev;
        n_oaddr = r_oaddr; n_ogr = r_ogr; n_ofree = r_ofree; n_ook = r_ook;
        n_omv = r_omv; n_oerr = r_oerr; n_ovalid = r_ovalid;
        mem_we = 1'b0; mem_wa = r_i[IdxW-1:0]; mem_ra = r_i[IdxW-1:0]; mem_wd = r_rd;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                n_oaddr = '0; n_ogr = '0; n_ook = 1'b0; n_omv = 1'b0;
                n_oerr = ERR_NONE; n_need = need_c; n_i = '0;
                if (r_op == OP_ALLOC || (r_op == OP_RESIZE && r_ua == 32'd0)) begin
                    n_state = need_c[32] ? S_OUT : S_G_SCAN;
                    if (need_c[32]) n_oerr = ERR_OOM;
                end else if (r_op == OP_FREE) begin
                    n_ook = 1'b1;
                    if (r_ua != '0 && r_hdr != '0) begin
                        n_ab = r_ua - HeaderBytes; n_al = r_hdr; n_ctx = C_FREE;
                        n_hasprev = 1'b0; n_state = S_A_SCAN;
                    end else begin
                        n_state = S_OUT;
                    end
                end else if (r_op == OP_RESIZE) begin
                    if (old_pay >= r_req) begin
                        n_oaddr = r_ua; n_ogr = r_hdr; n_ook = 1'b1; n_state = S_OUT;
                    end else begin
                        n_state = need_c[32] ? S_OUT : S_G_SCAN;
                        if (need_c[32]) n_oerr = ERR_OOM;
                    end
                end else begin
                    n_state = S_OUT;
                end
            end
            S_G_SCAN: begin
                mem_ra = r_i[IdxW-1:0];
                n_state = (r_i >= r_cnt) ? S_G_GROW : S_G_SCAN_W;
            end
            S_G_SCAN_W: begin
                if ({1'b0, e_len} >= r_need) begin
                    n_state = S_G_TAKE;
                end else begin
                    n_i = r_i + 1'b1;
                    n_state = S_G_SCAN;
                end
            end
            S_G_GROW: begin
                if (nbrk[32] || nbrk > lim) begin
                    n_oerr = ERR_OOM; n_state = S_OUT;
                end else begin
                    n_ab = r_brk; n_al = chunk[31:0]; n_ctx = C_GROW;
                    n_hasprev = 1'b0; n_i = '0; n_state = S_A_SCAN;
                end
            end
            S_G_TAKE_RD: begin
                mem_ra = r_i[IdxW-1:0];
                n_state = S_G_TAKE_W;
            end
            S_G_TAKE_W: begin
                n_state = S_G_TAKE;
            end
            S_G_TAKE: begin
                n_oaddr = e_base + HeaderBytes;
                n_ook = 1'b1; n_omv = (r_op == OP_RESIZE && r_ua != '0);
                if ({1'b0, e_len} >= r_need + {1'b0, HeaderBytes} + (PtrBytes << 1)) begin
                    n_ogr = r_need[31:0];
                    mem_we = 1'b1; mem_wa = r_i[IdxW-1:0];
                    mem_wd = {e_base + r_need[31:0], e_len - r_need[31:0]};
                    n_free = r_free - r_need[31:0];
                    n_state = S_A_DONE;
                end else begin
                    n_ogr = e_len;
                    n_free = r_free - e_len;
                    n_j = r_i;
                    n_state = S_G_DROP_RD;
                end
                n_ctx = C_OLD;
            end
            // shift entries j+1.. down by one, then shrink the count
            S_G_DROP_RD: begin
                if (r_j + 1'b1 >= r_cnt) begin
                    n_cnt = r_cnt - 1'b1;
                    n_state = S_A_DONE;
                end else begin
                    mem_ra = IdxW'(r_j + 1'b1);
                    n_state = S_G_DROP_W;
                end
            end
            S_G_DROP_W: begin
                mem_ra = IdxW'(r_j + 1'b1);
                n_state = S_G_DROP_WR;
            end
            S_G_DROP_WR: begin
                mem_we = 1'b1; mem_wa = r_j[IdxW-1:0]; mem_wd = r_rd;
                n_j = r_j + 1'b1; n_state = S_G_DROP_RD;
            end
            S_A_SCAN: begin
                mem_ra = r_i[IdxW-1:0];
                n_state = (r_i >= r_cnt) ? S_A_DECIDE : S_A_SCAN_W;
            end
            S_A_SCAN_W: begin
                if (e_base <= r_ab) begin
                    n_prev = r_rd; n_hasprev = 1'b1;
                    n_i = r_i + 1'b1; n_state = S_A_SCAN;
                end else begin
                    n_state = S_A_DECIDE;
                end
            end
            S_A_PREV_RD, S_A_PREV_W, S_A_NEXT_W: n_state = S_A_DECIDE;
            // r_rd holds entry i when i < count
            S_A_DECIDE: begin
                if (r_hasprev && p_end == r_ab) begin
                    n_free = r_free + r_al;
                    n_prev[31:0] = r_prev[31:0] + r_al;
                    if (r_i < r_cnt && r_prev[63:32] + n_prev[31:0] == e_base) begin
                        n_prev[31:0] = n_prev[31:0] + e_len;
                        n_j = r_i; n_state = S_A_MDROP_RD;
                    end else begin
                        n_state = S_A_DONE;
                    end
                    mem_we = 1'b1; mem_wa = IdxW'(r_i - 1'b1); mem_wd = n_prev;
                    n_i = r_i - 1'b1;
                end else if (r_i < r_cnt && r_ab + r_al == e_base) begin
                    n_free = r_free + r_al;
                    mem_we = 1'b1; mem_wa = r_i[IdxW-1:0];
                    mem_wd = {r_ab, e_len + r_al};
                    n_state = S_A_DONE;
                end else if (r_cnt >= CntW'(MaxHoles)) begin
                    n_state = S_A_DONE;
                    if (r_ctx == C_GROW) begin
                        n_oerr = ERR_FULL;
                        n_state = S_OUT;
                    end else if (r_ctx == C_FREE) begin
                        n_ook = 1'b0; n_oerr = ERR_FULL; n_state = S_OUT;
                    end else begin
                        n_oerr = ERR_FULL; n_state = S_OUT;
                    end
                end else begin
                    n_free = r_free + r_al;
                    n_j = r_cnt; n_state = S_A_INS_RD;
                end
            end
            S_A_MDROP_RD: begin
                if (r_j + 1'b1 >= r_cnt) begin
                    n_cnt = r_cnt - 1'b1; n_state = S_A_DONE;
                end else begin
                    mem_ra = IdxW'(r_j + 1'b1); n_state = S_A_MDROP_W;
                end
            end
            S_A_MDROP_W: begin
                mem_ra = IdxW'(r_j + 1'b1);
                n_state = S_A_MDROP_WR;
            end
            S_A_MDROP_WR: begin
                mem_we = 1'b1; mem_wa = r_j[IdxW-1:0]; mem_wd = r_rd;
                n_j = r_j + 1'b1; n_state = S_A_MDROP_RD;
            end
            // open a gap at i by shifting entries up from the top
            S_A_INS_RD: begin
                if (r_j == r_i) begin
                    mem_we = 1'b1; mem_wa = r_i[IdxW-1:0]; mem_wd = {r_ab, r_al};
                    n_cnt = r_cnt + 1'b1; n_state = S_A_DONE;
                end else begin
                    mem_ra = IdxW'(r_j - 1'b1); n_state = S_A_INS_W;
                end
            end
            S_A_INS_W: begin
                mem_ra = IdxW'(r_j - 1'b1);
                n_state = S_A_INS_WR;
            end
            S_A_INS_WR: begin
                mem_we = 1'b1; mem_wa = r_j[IdxW-1:0]; mem_wd = r_rd;
                n_j = r_j - 1'b1; n_state = S_A_INS_RD;
            end
            S_A_DONE: begin
                if (r_ctx == C_GROW) begin
                    // new hole index is r_i; now take from it
                    n_brk = nbrk[31:0];
                    n_state = S_G_TAKE_RD;
                end else if (r_ctx == C_OLD && r_op == OP_RESIZE && r_ua != '0 &&
                        r_hdr != '0) begin
                    // return the old block; a full table keeps the move a success
                    n_ab = r_ua - HeaderBytes; n_al = r_hdr; n_ctx = C_MOVE;
                    n_hasprev = 1'b0; n_i = '0; n_state = S_A_SCAN;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                n_ofree = r_free;
                if (!r_ovalid) begin
                    n_ovalid = 1'b1;
                end else if (!i_stall) begin
                    n_ovalid = 1'b0; n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        if (r_ovalid && !i_stall && r_state != S_OUT) n_ovalid = 1'b0;
    end

    property p_cnt_bound;
        @(posedge i_clk) disable iff (!i_rst_n) r_cnt <= CntW'(MaxHoles);
    endproperty
    a_cnt_bound: assert property (p_cnt_bound) else $error("hole count overflow");

    property p_out_busy;
        @(posedge i_clk) disable iff (!i_rst_n) o_valid |-> o_stall;
    endproperty
    a_out_busy: assert property (p_out_busy) else $error("result shown while idle");

    property p_fail_zero;
        @(posedge i_clk) disable iff (!i_rst_n)
            (o_valid && !o_success) |-> (o_result_address == '0 && o_moved == 1'b0);
    endproperty
    a_fail_zero: assert property (p_fail_zero) else $error("failed result not cleared");
endmodule
